// ===== sv/nggz_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nggz_pkg
// shared types and constants of the gga / zda sentence parser
// ----------------------------------------------------------------------------
package nggz_pkg;

  // ascii codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [7:0] CH_Z      = 8'h5A;

  localparam int unsigned TOK_DEPTH_DEF = 2;
  localparam int unsigned RES_DEPTH_DEF = 2;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_DOLLAR,
    CLS_COMMA,
    CLS_END,
    CLS_DIGIT,
    CLS_DOT,
    CLS_MINUS,
    CLS_PLUS
  } cls_e;

  typedef struct packed {
    cls_e       cls;
    logic [7:0] ch;
  } tok_t;

  typedef struct packed {
    logic               sentence_type;
    logic [6:0]         hour;
    logic [6:0]         minute;
    logic [16:0]        millis;
    logic signed [26:0] latitude;
    logic signed [30:0] longitude;
    logic [6:0]         satellites;
    logic signed [20:0] altitude_dm;
    logic [6:0]         day;
    logic [6:0]         month;
    logic [13:0]        year;
  } res_t;

endpackage

// ===== sv/nggz_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nggz_fifo
// small register queue, one write and one read port
// ----------------------------------------------------------------------------
module nggz_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL_CNT)
    else $error("queue count above depth");

  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> (cnt_q == $past(cnt_q) - CW'(1)))
    else $error("pop did not lower count");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

endmodule

// ===== sv/nggz_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nggz_front
// character classifier ahead of the token queue
// ----------------------------------------------------------------------------
module nggz_front
  import nggz_pkg::*;
(
  input  logic [7:0] char_byte_i,
  output tok_t       tok_o
);

  cls_e cls;

  always_comb begin
    unique case (char_byte_i) inside
      CH_DOLLAR:              cls = CLS_DOLLAR;
      CH_COMMA:               cls = CLS_COMMA;
      CH_STAR, CH_CR, CH_LF:  cls = CLS_END;
      [CH_ZERO:CH_NINE]:      cls = CLS_DIGIT;
      CH_DOT:                 cls = CLS_DOT;
      CH_MINUS:               cls = CLS_MINUS;
      CH_PLUS:                cls = CLS_PLUS;
      default:                cls = CLS_OTHER;
    endcase
  end

  assign tok_o.cls = cls;
  assign tok_o.ch  = char_byte_i;

endmodule

// ===== sv/nggz_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nggz_back
// sentence parser: header match, field split, fixed point conversion
// ----------------------------------------------------------------------------
module nggz_back
  import nggz_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic tok_valid_i,
  input  tok_t tok_i,
  output logic res_push_o,
  output res_t res_o
);

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_GGA,
    KIND_ZDA
  } kind_e;

  typedef struct packed {
    logic       valid;
    logic [2:0] wa;
    logic [2:0] wb;
    logic [2:0] wc;
    logic [2:0] fm;
    logic       dot;
  } spec_t;

  localparam logic [2:0] HDR_IDLE = 3'd0;
  localparam logic [2:0] HDR_LAST = 3'd6;
  localparam logic [2:0] HDR_BODY = 3'd7;
  localparam logic [19:0] ALT_SAT = 20'd999999;
  localparam logic [16:0] ACC_SAT = 17'd100000;

  function automatic spec_t field_spec(kind_e k, logic [3:0] fn);
    spec_t s;
    s = '0;
    if (k == KIND_GGA) begin
      case (fn)
        4'd0:    s = '{1'b1, 3'd2, 3'd2, 3'd2, 3'd3, 1'b1};
        4'd1:    s = '{1'b1, 3'd2, 3'd2, 3'd0, 3'd4, 1'b1};
        4'd3:    s = '{1'b1, 3'd3, 3'd2, 3'd0, 3'd4, 1'b1};
        4'd6:    s = '{1'b1, 3'd2, 3'd0, 3'd0, 3'd0, 1'b0};
        default: s = '0;
      endcase
    end else if (k == KIND_ZDA) begin
      if (fn == 4'd1 || fn == 4'd2) s = '{1'b1, 3'd2, 3'd0, 3'd0, 3'd0, 1'b0};
      else if (fn == 4'd3)          s = '{1'b1, 3'd4, 3'd0, 3'd0, 3'd0, 1'b0};
    end
    return s;
  endfunction

  // control
  logic [2:0]  hp_q, hp_d;
  kind_e       kind_q, kind_d;
  logic [3:0]  fn_q, fn_d;
  logic        fail_q, fail_d;
  // field scanner
  logic [2:0]  dp_q, dp_d;
  logic [16:0] acc_q, acc_d;
  logic [6:0]  acc2_q, acc2_d;
  logic [6:0]  acc3_q, acc3_d;
  logic [15:0] dm_q, dm_d;       // degrees*60 + minutes, kept as digits arrive
  logic [13:0] frac_q, frac_d;   // fraction already scaled to its digit count
  logic [2:0]  fcnt_q, fcnt_d;
  logic [1:0]  chars_q, chars_d;
  logic [7:0]  first_q, first_d;
  logic        dot_q, dot_d, stop_q, stop_d, neg_q, neg_d;
  // held values
  logic [6:0]         hour_q, hour_d, min_q, min_d, sats_q, sats_d;
  logic [16:0]        millis_q, millis_d;
  logic signed [26:0] lat_q, lat_d;
  logic signed [30:0] lon_q, lon_d;
  logic signed [20:0] alt_q, alt_d;
  logic [6:0]         day_q, day_d, mon_q, mon_d;
  logic [13:0]        year_q, year_d;

  // commit view of held values
  logic [6:0]         c_hour, c_min, c_sats, c_day, c_mon;
  logic [16:0]        c_millis;
  logic signed [26:0] c_lat;
  logic signed [30:0] c_lon;
  logic signed [20:0] c_alt;
  logic [13:0]        c_year;
  logic               c_fail;
  logic [30:0]        ang_mag;
  logic [20:0]        alt_raw;
  logic [19:0]        alt_mag;

  // feed view of scanner
  logic [2:0]  f_dp, f_fcnt;
  logic [16:0] f_acc;
  logic [6:0]  f_acc2, f_acc3;
  logic [15:0] f_dm;
  logic [13:0] f_frac, frac_add;
  logic [1:0]  f_chars;
  logic [7:0]  f_first;
  logic        f_dot, f_stop, f_neg;
  logic [3:0]  dig;
  logic [1:0]  fexp;
  spec_t       sp;
  logic        hdr_match, ok;

  assign dig = tok_i.ch[3:0];
  assign sp  = field_spec(kind_q, fn_q);
  assign fexp = 2'(sp.fm - 3'd1 - fcnt_q);

  always_comb begin
    case (fexp)
      2'd0:    frac_add = 14'(dig);
      2'd1:    frac_add = 14'(dig) * 14'd10;
      2'd2:    frac_add = 14'(dig) * 14'd100;
      default: frac_add = 14'(dig) * 14'd1000;
    endcase
  end

  // commit of the field that a comma or the sentence end closes
  always_comb begin
    c_hour = hour_q; c_min = min_q; c_millis = millis_q; c_lat = lat_q;
    c_lon = lon_q; c_sats = sats_q; c_alt = alt_q; c_day = day_q;
    c_mon = mon_q; c_year = year_q; c_fail = fail_q;
    ang_mag = 31'(dm_q) * 31'd10000 + 31'(frac_q);
    alt_raw = 21'(acc_q) * 21'd10 + 21'(frac_q[3:0]);
    alt_mag = (alt_raw > 21'(ALT_SAT)) ? ALT_SAT : alt_raw[19:0];
    if (kind_q == KIND_GGA) begin
      case (fn_q)
        4'd0: begin
          c_hour   = acc_q[6:0];
          c_min    = acc2_q;
          c_millis = 17'(acc3_q) * 17'd1000 + 17'(frac_q);
        end
        4'd1: c_lat = ang_mag[26:0];
        4'd2: begin
          if (first_q == CH_S)      c_lat = -lat_q;
          else if (first_q != CH_N) c_fail = 1'b1;
        end
        4'd3: c_lon = ang_mag;
        4'd4: begin
          if (first_q == CH_W)      c_lon = -lon_q;
          else if (first_q != CH_E) c_fail = 1'b1;
        end
        4'd6: c_sats = acc_q[6:0];
        4'd8: c_alt = neg_q ? -$signed({1'b0, alt_mag}) : $signed({1'b0, alt_mag});
        default: ;
      endcase
    end else if (kind_q == KIND_ZDA && fn_q <= 4'd3) begin
      if (chars_q == 2'd0) c_fail = 1'b1;
      if (fn_q == 4'd1)      c_day  = acc_q[6:0];
      else if (fn_q == 4'd2) c_mon  = acc_q[6:0];
      else if (fn_q == 4'd3) c_year = acc_q[13:0];
    end
  end

  // one character into the open field
  always_comb begin
    f_dp = dp_q; f_acc = acc_q; f_acc2 = acc2_q; f_acc3 = acc3_q; f_dm = dm_q;
    f_frac = frac_q; f_fcnt = fcnt_q; f_dot = dot_q; f_stop = stop_q; f_neg = neg_q;
    f_first = (chars_q == 2'd0) ? tok_i.ch : first_q;
    f_chars = (chars_q == 2'd3) ? chars_q : chars_q + 2'd1;
    if (!stop_q) begin
      if (kind_q == KIND_GGA && fn_q == 4'd8) begin
        // altitude: optional sign, saturating integer, one fraction digit
        if (tok_i.cls == CLS_DIGIT) begin
          if (dot_q) begin
            if (fcnt_q == 3'd0) begin
              f_frac = 14'(dig);
              f_fcnt = 3'd1;
            end
          end else begin
            f_acc = (acc_q >= 17'd10000) ? ACC_SAT : 17'(acc_q * 17'd10 + 17'(dig));
            if (f_acc > ACC_SAT) f_acc = ACC_SAT;
          end
        end else if ((tok_i.cls == CLS_MINUS || tok_i.cls == CLS_PLUS) && chars_q == 2'd0) begin
          f_neg = (tok_i.cls == CLS_MINUS);
        end else if (tok_i.cls == CLS_DOT && !dot_q) begin
          f_dot = 1'b1;
        end else begin
          f_stop = 1'b1;
        end
      end else if (sp.valid) begin
        if (tok_i.cls == CLS_DIGIT) begin
          if (dot_q) begin
            if (fcnt_q < sp.fm) begin
              f_frac = frac_q + frac_add;
              f_fcnt = fcnt_q + 3'd1;
            end
          end else if (4'(dp_q) < 4'(sp.wa)) begin
            f_acc = 17'(acc_q * 17'd10 + 17'(dig));
            f_dm  = 16'(dm_q * 16'd10 + 16'(dig) * 16'd60);
            f_dp  = dp_q + 3'd1;
          end else if (4'(dp_q) < 4'(sp.wa) + 4'(sp.wb)) begin
            f_acc2 = 7'(acc2_q * 7'd10 + 7'(dig));
            f_dm   = 16'(dm_q + 16'(acc2_q) * 16'd9 + 16'(dig));
            f_dp   = dp_q + 3'd1;
          end else if (4'(dp_q) < 4'(sp.wa) + 4'(sp.wb) + 4'(sp.wc)) begin
            f_acc3 = 7'(acc3_q * 7'd10 + 7'(dig));
            f_dp   = dp_q + 3'd1;
          end else begin
            f_stop = 1'b1;
          end
        end else if (tok_i.cls == CLS_DOT && sp.dot && !dot_q) begin
          f_dot = 1'b1;
        end else begin
          f_stop = 1'b1;
        end
      end
    end
  end

  always_comb begin
    unique case (hp_q)
      3'd1:    hdr_match = (tok_i.ch == CH_G);
      3'd2:    hdr_match = (tok_i.ch == CH_N);
      3'd3:    hdr_match = (tok_i.ch == CH_G) || (tok_i.ch == CH_Z);
      3'd4:    hdr_match = (kind_q == KIND_GGA) ? (tok_i.ch == CH_G) : (tok_i.ch == CH_D);
      3'd5:    hdr_match = (tok_i.ch == CH_A);
      default: hdr_match = (tok_i.cls == CLS_COMMA);
    endcase
  end

  assign ok = !c_fail && ((kind_q == KIND_GGA) ? (fn_q >= 4'd8) : (fn_q >= 4'd3));

  always_comb begin
    hp_d = hp_q; kind_d = kind_q; fn_d = fn_q; fail_d = fail_q;
    dp_d = dp_q; acc_d = acc_q; acc2_d = acc2_q; acc3_d = acc3_q; dm_d = dm_q;
    frac_d = frac_q; fcnt_d = fcnt_q; chars_d = chars_q; first_d = first_q;
    dot_d = dot_q; stop_d = stop_q; neg_d = neg_q;
    hour_d = hour_q; min_d = min_q; millis_d = millis_q; lat_d = lat_q; lon_d = lon_q;
    sats_d = sats_q; alt_d = alt_q; day_d = day_q; mon_d = mon_q; year_d = year_q;
    res_push_o = 1'b0;
    res_o = '0;
    if (tok_valid_i) begin
      if (tok_i.cls == CLS_DOLLAR) begin
        hp_d   = 3'd1;
        kind_d = KIND_NONE;
      end else if (hp_q == HDR_IDLE) begin
        hp_d = hp_q;
      end else if (hp_q != HDR_BODY) begin
        if (!hdr_match) begin
          hp_d   = HDR_IDLE;
          kind_d = KIND_NONE;
        end else begin
          hp_d = hp_q + 3'd1;
          if (hp_q == 3'd3) kind_d = (tok_i.ch == CH_G) ? KIND_GGA : KIND_ZDA;
          if (hp_q == HDR_LAST) begin
            // header complete: fresh sentence
            fn_d = '0; fail_d = 1'b0;
            dp_d = '0; acc_d = '0; acc2_d = '0; acc3_d = '0; dm_d = '0; frac_d = '0;
            fcnt_d = '0; chars_d = '0; first_d = '0; dot_d = 1'b0; stop_d = 1'b0;
            neg_d = 1'b0;
            hour_d = '0; min_d = '0; millis_d = '0; lat_d = '0; lon_d = '0;
            sats_d = '0; alt_d = '0; day_d = '0; mon_d = '0; year_d = '0;
          end
        end
      end else if (tok_i.cls == CLS_COMMA || tok_i.cls == CLS_END) begin
        hour_d = c_hour; min_d = c_min; millis_d = c_millis; lat_d = c_lat;
        lon_d = c_lon; sats_d = c_sats; alt_d = c_alt; day_d = c_day;
        mon_d = c_mon; year_d = c_year; fail_d = c_fail;
        if (tok_i.cls == CLS_COMMA) begin
          if (fn_q != 4'd15) fn_d = fn_q + 4'd1;
          dp_d = '0; acc_d = '0; acc2_d = '0; acc3_d = '0; dm_d = '0; frac_d = '0;
          fcnt_d = '0; chars_d = '0; first_d = '0; dot_d = 1'b0; stop_d = 1'b0;
          neg_d = 1'b0;
        end else begin
          hp_d   = HDR_IDLE;
          kind_d = KIND_NONE;
          if (ok) begin
            res_push_o = 1'b1;
            if (kind_q == KIND_GGA) begin
              res_o.hour        = c_hour;
              res_o.minute      = c_min;
              res_o.millis      = c_millis;
              res_o.latitude    = c_lat;
              res_o.longitude   = c_lon;
              res_o.satellites  = c_sats;
              res_o.altitude_dm = c_alt;
            end else begin
              res_o.sentence_type = 1'b1;
              res_o.day   = c_day;
              res_o.month = c_mon;
              res_o.year  = c_year;
            end
          end
        end
      end else begin
        dp_d = f_dp; acc_d = f_acc; acc2_d = f_acc2; acc3_d = f_acc3; dm_d = f_dm;
        frac_d = f_frac; fcnt_d = f_fcnt; chars_d = f_chars; first_d = f_first;
        dot_d = f_dot; stop_d = f_stop; neg_d = f_neg;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q <= HDR_IDLE; kind_q <= KIND_NONE; fn_q <= '0; fail_q <= 1'b0;
      dp_q <= '0; acc_q <= '0; acc2_q <= '0; acc3_q <= '0; dm_q <= '0; frac_q <= '0;
      fcnt_q <= '0; chars_q <= '0; first_q <= '0; dot_q <= 1'b0; stop_q <= 1'b0;
      neg_q <= 1'b0;
      hour_q <= '0; min_q <= '0; millis_q <= '0; lat_q <= '0; lon_q <= '0;
      sats_q <= '0; alt_q <= '0; day_q <= '0; mon_q <= '0; year_q <= '0;
    end else begin
      hp_q <= hp_d; kind_q <= kind_d; fn_q <= fn_d; fail_q <= fail_d;
      dp_q <= dp_d; acc_q <= acc_d; acc2_q <= acc2_d; acc3_q <= acc3_d; dm_q <= dm_d;
      frac_q <= frac_d; fcnt_q <= fcnt_d; chars_q <= chars_d; first_q <= first_d;
      dot_q <= dot_d; stop_q <= stop_d; neg_q <= neg_d;
      hour_q <= hour_d; min_q <= min_d; millis_q <= millis_d; lat_q <= lat_d;
      lon_q <= lon_d; sats_q <= sats_d; alt_q <= alt_d; day_q <= day_d;
      mon_q <= mon_d; year_q <= year_d;
    end
  end

endmodule

// ===== sv/nmea_gga_zda_sentence_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_gga_zda_sentence_parser
// byte stream parser for gga position and zda date sentences
// ----------------------------------------------------------------------------
// channel   direction  handshake        payload
// input     in         push / full      char_byte_i
// result    out        pop / empty      sentence_type_o .. year_o
//
// one character per cycle sustained unless the result queue is full; a result
// is pushed once its closing '*', cr or lf is popped (classify, queue, parse)
// the parser loop itself is a combinational update of the scanner registers
// reset clears all state but the queue storage at once, no clearing pass
// a stalled result side fills the result queue, then the token queue, then
// raises full
// ----------------------------------------------------------------------------
module nmea_gga_zda_sentence_parser
  import nggz_pkg::*;
#(
  parameter int unsigned TOK_DEPTH = TOK_DEPTH_DEF,
  parameter int unsigned RES_DEPTH = RES_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         char_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic               sentence_type_o,
  output logic [6:0]         hour_o,
  output logic [6:0]         minute_o,
  output logic [16:0]        millis_o,
  output logic signed [26:0] latitude_o,
  output logic signed [30:0] longitude_o,
  output logic [6:0]         satellites_o,
  output logic signed [20:0] altitude_dm_o,
  output logic [6:0]         day_o,
  output logic [6:0]         month_o,
  output logic [13:0]        year_o
);

  tok_t tok_in, tok_out;
  res_t res_in, res_out;
  logic tok_empty, tok_pop;
  logic res_full, res_push;

  // front: classify the incoming character
  nggz_front u_front (
    .char_byte_i (char_byte_i),
    .tok_o       (tok_in)
  );

  // token queue between classifier and parser
  nggz_fifo #(
    .WIDTH ($bits(tok_t)),
    .DEPTH (TOK_DEPTH)
  ) u_tok_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (tok_in),
    .pop_i   (tok_pop),
    .rdata_o (tok_out),
    .full_o  (full),
    .empty_o (tok_empty)
  );

  // parser takes a token only when a result slot is free
  assign tok_pop = !tok_empty && !res_full;

  nggz_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_pop),
    .tok_i       (tok_out),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // result queue decouples the parser from the consumer
  nggz_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .pop_i   (pop),
    .rdata_o (res_out),
    .full_o  (res_full),
    .empty_o (empty)
  );

  assign sentence_type_o = res_out.sentence_type;
  assign hour_o          = res_out.hour;
  assign minute_o        = res_out.minute;
  assign millis_o        = res_out.millis;
  assign latitude_o      = res_out.latitude;
  assign longitude_o     = res_out.longitude;
  assign satellites_o    = res_out.satellites;
  assign altitude_dm_o   = res_out.altitude_dm;
  assign day_o           = res_out.day;
  assign month_o         = res_out.month;
  assign year_o          = res_out.year;

endmodule
